// File: rtl/core/bcva_pkg.sv
`default_nettype none
package bcva_pkg;

   localparam int unsigned MAX_FRAMES  = 1024;
   localparam int unsigned NUM_CLASSES = 32;
   localparam int unsigned MAX_TARGETS = 127;
   localparam int unsigned MAX_BAND    = 64;

   localparam int unsigned FRAME_W = 10;   // frame address
   localparam int unsigned COUNT_W = 11;   // frame count, up to MAX_FRAMES
   localparam int unsigned CLASS_W = 5;
   localparam int unsigned TGT_W   = 7;
   localparam int unsigned STATE_W = 8;    // extended state index
   localparam int unsigned OFF_W   = 6;    // offset within a band
   localparam int unsigned LOGIT_W = 16;
   localparam int unsigned VAL_W   = 31;   // path score, sum of logits
   localparam int unsigned ROW_W   = VAL_W + 1;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 11;

   localparam logic [2:0] MODE_LABEL = 3'd0;
   localparam logic [2:0] MODE_BAND  = 3'd1;
   localparam logic [2:0] MODE_LOGIT = 3'd2;
   localparam logic [2:0] MODE_START = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_PATH = 2'd1;
   localparam logic [1:0] STATUS_BAND    = 2'd2;
   localparam logic [1:0] STATUS_LONG    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_CLASS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_COUNT = 2'd2;

endpackage
`default_nettype wire

// File: rtl/core/bcva_req_if.sv
`default_nettype none
interface bcva_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [9:0]  index;
   logic [4:0]  class_index;
   logic signed [15:0] score;
   logic [7:0]  band_low;
   logic [8:0]  band_high;

   modport source (output valid, mode, index, class_index, score, band_low, band_high,
                   input ready);
   modport sink (input valid, mode, index, class_index, score, band_low, band_high,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/core/bcva_rsp_if.sv
`default_nettype none
interface bcva_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] frame;
   logic [7:0]  state;
   logic [1:0]  status;

   modport source (output valid, frame, state, status, input ready);
   modport sink (input valid, frame, state, status, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bcva_csr_if.sv
`default_nettype none
interface bcva_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [10:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/banded_ctc_viterbi_aligner.sv
// Load items (label, band, logit) are written in idle; a frame read waits in
// the read state for the result register. Start: band checks of all frames,
// then per frame a band load, a sweep at one state per cycle through the
// score-row memory and a drain, then final states and a backtrace through the
// pointer memory. Synchronous active-high reset clears control and registers;
// the stores hold whatever was last written and need no clearing.
`default_nettype none
module banded_ctc_viterbi_aligner (
   input  wire  clock,
   input  wire  reset,
   bcva_req_if.sink   req_if,
   bcva_rsp_if.source rsp_if,
   bcva_csr_if.sink   csr_if
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_CK_ISSUE, ST_CK_TEST, ST_FR_LOAD, ST_FR_BAND, ST_SWEEP,
      ST_DRAIN, ST_FIN1, ST_FIN2, ST_FIN3, ST_BT1, ST_BT2, ST_BT3, ST_DONE
   } state_type;

   localparam int unsigned VW = bcva_pkg::VAL_W;

   state_type state_ff;

   // configuration
   logic [bcva_pkg::CLASS_W-1:0] blank_ff;
   logic [bcva_pkg::COUNT_W-1:0] frames_ff;
   logic [bcva_pkg::TGT_W-1:0]   targets_ff;

   // run control
   logic [bcva_pkg::COUNT_W-1:0] tc_ff;
   logic [bcva_pkg::STATE_W-1:0] ext_ff;      // S = 2n+1
   logic [bcva_pkg::FRAME_W-1:0] t_ff;
   logic [bcva_pkg::STATE_W-1:0] prev_lo_ff;  // band check
   logic [bcva_pkg::STATE_W-1:0] lo_ff, plo_ff;
   logic [8:0]                   hi_ff, phi_ff;
   logic                         first_ff;
   logic                         row_sel_ff;
   logic signed [9:0]            j_ff;
   logic [1:0]                   status_ff, last_status_ff;
   logic [bcva_pkg::STATE_W-1:0] best_ff;
   logic                         fin_ok_ff;
   logic signed [VW-1:0]         fin_v_ff;
   logic                         bt_hit_ff;

   // sweep pipeline
   logic                         rd_valid_ff;
   logic signed [9:0]            rd_j_ff;
   logic                         wr_valid_ff, wr_ok_ff;
   logic [bcva_pkg::STATE_W-1:0] wr_j_ff;
   logic signed [VW-1:0]         wr_v_ff;
   logic                         w1_ok_ff, w2_ok_ff;
   logic signed [VW-1:0]         w1_v_ff, w2_v_ff;
   logic [bcva_pkg::CLASS_W-1:0] odd_lab_ff;

   // result
   logic        rsp_valid_ff;
   logic [10:0] rsp_frame_ff;
   logic [7:0]  rsp_state_ff;
   logic [1:0]  rsp_status_ff;

   // memories
   logic [bcva_pkg::CLASS_W-1:0] label_mem [bcva_pkg::MAX_TARGETS+1];
   logic [7:0]                   band_lo_mem [bcva_pkg::MAX_FRAMES];
   logic [8:0]                   band_hi_mem [bcva_pkg::MAX_FRAMES];
   logic [bcva_pkg::LOGIT_W-1:0] logit_mem [bcva_pkg::MAX_FRAMES*bcva_pkg::NUM_CLASSES];
   logic [bcva_pkg::ROW_W-1:0]   row_mem [512];
   logic [1:0]                   bp_mem [bcva_pkg::MAX_FRAMES*bcva_pkg::MAX_BAND];
   logic [7:0]                   path_mem [bcva_pkg::MAX_FRAMES];

   logic [bcva_pkg::CLASS_W-1:0] label_rdata_ff;
   logic [7:0]                   band_lo_rdata_ff;
   logic [8:0]                   band_hi_rdata_ff;
   logic signed [bcva_pkg::LOGIT_W-1:0] logit_rdata_ff;
   logic [bcva_pkg::ROW_W-1:0]   row_rdata_ff;
   logic [1:0]                   bp_rdata_ff;
   logic [7:0]                   path_rdata_ff;

   logic req_acc, csr_acc, rsp_free, rsp_load;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign csr_acc      = csr_if.valid;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign rsp_load     = ((state_ff == ST_READ) || (state_ff == ST_DONE)) && rsp_free;

   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.frame  = rsp_frame_ff;
   assign rsp_if.state  = rsp_state_ff;
   assign rsp_if.status = rsp_status_ff;

   // clamped counts at start
   logic [bcva_pkg::COUNT_W-1:0] tc_in;
   logic [bcva_pkg::TGT_W-1:0]   nc;
   logic [bcva_pkg::STATE_W-1:0] ext_in;
   always_comb begin
      if (frames_ff == '0) tc_in = 11'd1;
      else if (frames_ff > 11'(bcva_pkg::MAX_FRAMES)) tc_in = 11'(bcva_pkg::MAX_FRAMES);
      else tc_in = frames_ff;
      nc     = (targets_ff == '0) ? 7'd1 : targets_ff;
      ext_in = {nc, 1'b1};
   end

   // entry of the previous score row, with band and first-frame handling
   logic signed [9:0]    ent_idx;
   logic                 ent_ok;
   logic signed [VW-1:0] ent_v;
   always_comb begin
      if (state_ff == ST_FIN2) ent_idx = $signed({2'b00, ext_ff}) - 10'sd1;
      else if (state_ff == ST_FIN3) ent_idx = $signed({2'b00, ext_ff}) - 10'sd2;
      else ent_idx = rd_j_ff;
      if (first_ff) begin
         ent_ok = (ent_idx == 10'sd0);
         ent_v  = '0;
      end else begin
         ent_ok = (ent_idx >= $signed({2'b00, plo_ff})) &&
                  (ent_idx < $signed({1'b0, phi_ff})) && row_rdata_ff[VW];
         ent_v  = $signed(row_rdata_ff[VW-1:0]);
      end
   end

   // score choice for the state leaving the read stage
   logic                 produce, ch_ok;
   logic signed [VW-1:0] ch_v;
   logic [1:0]           ch_back;
   logic [bcva_pkg::CLASS_W-1:0] cls;
   logic [9:0]           off10;
   always_comb begin
      produce = rd_valid_ff && (rd_j_ff >= $signed({2'b00, lo_ff}));
      ch_ok   = ent_ok;
      ch_v    = ent_v;
      ch_back = 2'd0;
      if (w1_ok_ff && (!ch_ok || w1_v_ff > ch_v)) begin
         ch_ok = 1'b1; ch_v = w1_v_ff; ch_back = 2'd1;
      end
      if (rd_j_ff[0] && rd_j_ff >= 10'sd3 && label_rdata_ff != odd_lab_ff && w2_ok_ff &&
          (!ch_ok || w2_v_ff > ch_v)) begin
         ch_ok = 1'b1; ch_v = w2_v_ff; ch_back = 2'd2;
      end
      cls   = rd_j_ff[0] ? label_rdata_ff : blank_ff;
      off10 = rd_j_ff - $signed({2'b00, lo_ff});
   end

   // backtrace offset
   logic [8:0] bt_off;
   logic       bt_hit;
   always_comb begin
      bt_off = {1'b0, best_ff} - {1'b0, band_lo_rdata_ff};
      bt_hit = (best_ff >= band_lo_rdata_ff) && (bt_off < 9'(bcva_pkg::MAX_BAND));
   end

   // band check of the frame just read
   logic [9:0] band_span;
   logic       band_bad;
   always_comb begin
      band_span = {1'b0, band_hi_rdata_ff} - {2'b00, band_lo_rdata_ff};
      band_bad  = (band_hi_rdata_ff <= {1'b0, band_lo_rdata_ff}) ||
                  (band_hi_rdata_ff > {1'b0, ext_ff}) ||
                  (band_span > 10'(bcva_pkg::MAX_BAND)) ||
                  ((t_ff != '0) && (band_lo_rdata_ff < prev_lo_ff));
   end

   // memory address and enable selection
   logic        lab_we, band_we, logit_we, row_we, bp_we, path_we;
   logic [6:0]  lab_raddr;
   logic [14:0] logit_raddr;
   logic [8:0]  row_raddr;
   logic [15:0] bp_waddr, bp_raddr;
   logic [9:0]  path_raddr;
   logic [bcva_pkg::ROW_W-1:0] row_wdata;
   logic signed [VW-1:0] wr_sum;
   always_comb begin
      lab_we   = req_acc && req_if.mode == bcva_pkg::MODE_LABEL &&
                 req_if.index < 10'(bcva_pkg::MAX_TARGETS);
      band_we  = req_acc && req_if.mode == bcva_pkg::MODE_BAND;
      logit_we = req_acc && req_if.mode == bcva_pkg::MODE_LOGIT;
      lab_raddr   = j_ff[7:1];
      logit_raddr = {t_ff, cls};
      if (state_ff == ST_FIN1) row_raddr = {row_sel_ff, ext_ff - 8'd1};
      else if (state_ff == ST_FIN2) row_raddr = {row_sel_ff, ext_ff - 8'd2};
      else row_raddr = {row_sel_ff, j_ff[7:0]};
      wr_sum    = wr_v_ff + {{(VW-bcva_pkg::LOGIT_W){logit_rdata_ff[15]}}, logit_rdata_ff};
      row_we    = wr_valid_ff;
      row_wdata = {wr_ok_ff, wr_ok_ff ? wr_sum : '0};
      bp_we     = produce;
      bp_waddr  = {t_ff, off10[bcva_pkg::OFF_W-1:0]};
      bp_raddr  = {t_ff, bt_off[bcva_pkg::OFF_W-1:0]};
      path_we   = (state_ff == ST_BT1);
      path_raddr = req_if.index;
   end

   always_ff @(posedge clock) begin
      if (lab_we) label_mem[req_if.index[6:0]] <= req_if.class_index;
      label_rdata_ff <= label_mem[lab_raddr];
   end

   always_ff @(posedge clock) begin
      if (band_we) begin
         band_lo_mem[req_if.index] <= req_if.band_low;
         band_hi_mem[req_if.index] <= req_if.band_high;
      end
      band_lo_rdata_ff <= band_lo_mem[t_ff];
      band_hi_rdata_ff <= band_hi_mem[t_ff];
   end

   always_ff @(posedge clock) begin
      if (logit_we) logit_mem[{req_if.index, req_if.class_index}] <= req_if.score;
      logit_rdata_ff <= logit_mem[logit_raddr];
   end

   always_ff @(posedge clock) begin
      if (row_we) row_mem[{~row_sel_ff, wr_j_ff}] <= row_wdata;
      row_rdata_ff <= row_mem[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (bp_we) bp_mem[bp_waddr] <= ch_back;
      bp_rdata_ff <= bp_mem[bp_raddr];
   end

   // hold the read data while the frame read waits for the result register
   always_ff @(posedge clock) begin
      if (path_we) path_mem[t_ff] <= best_ff;
      if (state_ff == ST_IDLE) path_rdata_ff <= path_mem[path_raddr];
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ff   <= '0;
         frames_ff  <= 11'd1;
         targets_ff <= 7'd1;
      end else if (csr_acc) begin
         case (csr_if.index)
            bcva_pkg::CSR_BLANK_CLASS:  blank_ff   <= csr_if.data[4:0];
            bcva_pkg::CSR_FRAME_COUNT:  frames_ff  <= csr_if.data;
            bcva_pkg::CSR_TARGET_COUNT: targets_ff <= csr_if.data[6:0];
            default: ;
         endcase
      end
   end

   // sweep pipeline: read stage, then logit add and write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= (state_ff == ST_SWEEP);
         wr_valid_ff <= produce;
      end
      rd_j_ff  <= j_ff;
      wr_j_ff  <= rd_j_ff[7:0];
      wr_ok_ff <= ch_ok;
      wr_v_ff  <= ch_v;
      if (rd_valid_ff) begin
         // slide the window of previous-row entries
         w2_ok_ff <= w1_ok_ff;
         w2_v_ff  <= w1_v_ff;
         w1_ok_ff <= ent_ok;
         w1_v_ff  <= ent_v;
         if (rd_j_ff[0]) odd_lab_ff <= label_rdata_ff;
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         last_status_ff <= bcva_pkg::STATUS_OK;
         status_ff      <= bcva_pkg::STATUS_OK;
         first_ff       <= 1'b0;
         row_sel_ff     <= 1'b0;
         t_ff           <= '0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready && !rsp_load) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_if.mode == bcva_pkg::MODE_START) begin
                     tc_ff  <= tc_in;
                     ext_ff <= ext_in;
                     t_ff   <= '0;
                     if ({3'b000, ext_in} > tc_in) begin
                        status_ff <= bcva_pkg::STATUS_LONG;
                        state_ff  <= ST_DONE;
                     end else begin
                        state_ff <= ST_CK_ISSUE;
                     end
                  end else if (req_if.mode == bcva_pkg::MODE_READ) begin
                     t_ff     <= req_if.index;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_frame_ff  <= {1'b0, t_ff};
                  rsp_state_ff  <= path_rdata_ff;
                  rsp_status_ff <= last_status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_CK_ISSUE: state_ff <= ST_CK_TEST;
            ST_CK_TEST: begin
               prev_lo_ff <= band_lo_rdata_ff;
               if (band_bad) begin
                  status_ff <= bcva_pkg::STATUS_BAND;
                  state_ff  <= ST_DONE;
               end else if ({1'b0, t_ff} == tc_ff - 11'd1) begin
                  t_ff       <= '0;
                  first_ff   <= 1'b1;
                  row_sel_ff <= 1'b0;
                  state_ff   <= ST_FR_LOAD;
               end else begin
                  t_ff     <= t_ff + 10'd1;
                  state_ff <= ST_CK_ISSUE;
               end
            end
            ST_FR_LOAD: state_ff <= ST_FR_BAND;
            ST_FR_BAND: begin
               lo_ff    <= band_lo_rdata_ff;
               hi_ff    <= band_hi_rdata_ff;
               // start two states early to fill the window
               j_ff     <= $signed({2'b00, band_lo_rdata_ff}) - 10'sd2;
               state_ff <= ST_SWEEP;
            end
            ST_SWEEP: begin
               if (j_ff == $signed({1'b0, hi_ff}) - 10'sd1) state_ff <= ST_DRAIN;
               else j_ff <= j_ff + 10'sd1;
            end
            ST_DRAIN: begin
               if (!rd_valid_ff && !wr_valid_ff) begin
                  plo_ff     <= lo_ff;
                  phi_ff     <= hi_ff;
                  row_sel_ff <= ~row_sel_ff;
                  first_ff   <= 1'b0;
                  if ({1'b0, t_ff} == tc_ff - 11'd1) begin
                     state_ff <= ST_FIN1;
                  end else begin
                     t_ff     <= t_ff + 10'd1;
                     state_ff <= ST_FR_LOAD;
                  end
               end
            end
            ST_FIN1: state_ff <= ST_FIN2;
            ST_FIN2: begin
               fin_ok_ff <= ent_ok;
               fin_v_ff  <= ent_v;
               state_ff  <= ST_FIN3;
            end
            ST_FIN3: begin
               if (ent_ok && (!fin_ok_ff || ent_v > fin_v_ff)) begin
                  best_ff  <= ext_ff - 8'd2;
                  state_ff <= ST_BT1;
               end else if (fin_ok_ff) begin
                  best_ff  <= ext_ff - 8'd1;
                  state_ff <= ST_BT1;
               end else begin
                  status_ff <= bcva_pkg::STATUS_NO_PATH;
                  state_ff  <= ST_DONE;
               end
            end
            ST_BT1: state_ff <= ST_BT2;
            ST_BT2: begin
               bt_hit_ff <= bt_hit;
               state_ff  <= ST_BT3;
            end
            ST_BT3: begin
               if (bt_hit_ff && {6'd0, bp_rdata_ff} <= best_ff)
                  best_ff <= best_ff - {6'd0, bp_rdata_ff};
               if (t_ff == '0) begin
                  status_ff <= bcva_pkg::STATUS_OK;
                  state_ff  <= ST_DONE;
               end else begin
                  t_ff     <= t_ff - 10'd1;
                  state_ff <= ST_BT1;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_frame_ff   <= tc_ff;
                  rsp_state_ff   <= '0;
                  rsp_status_ff  <= status_ff;
                  last_status_ff <= status_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !rd_valid_ff && !wr_valid_ff)
      else $error("sweep pipeline busy while idle");

   a_write_in_band: assert property (@(posedge clock) disable iff (reset)
      wr_valid_ff |-> wr_j_ff >= lo_ff && {1'b0, wr_j_ff} < hi_ff)
      else $error("score written outside the frame band");

   a_path_in_run: assert property (@(posedge clock) disable iff (reset)
      path_we |-> {1'b0, t_ff} < tc_ff && best_ff < ext_ff)
      else $error("path entry outside the run");

   a_rsp_after_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> rsp_valid_ff && rsp_frame_ff == tc_ff)
      else $error("start result not delivered");
`endif

endmodule
`default_nettype wire
